@@ src/correlating_branch_predictor_core_defines.svh @@
// Assertion macros for the correlating branch predictor core.
// Included by the core module; no other dependencies.
`ifndef CORRELATING_BRANCH_PREDICTOR_CORE_DEFINES_SVH
`define CORRELATING_BRANCH_PREDICTOR_CORE_DEFINES_SVH

// a at one edge implies b at the next
`define CBP_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// a implies b at the same edge
`define CBP_ASSERT_NOW(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`endif

@@ src/cbp_pkg.sv @@
// Shared constants and counter helpers for the correlating branch predictor.
// No dependencies.
package cbp_pkg;

  localparam int MAX_PC_BITS_DEF      = 10;
  localparam int MAX_HISTORY_BITS_DEF = 4;

  localparam logic [3:0] PC_BITS_RESET      = 4'd10;
  localparam logic [2:0] HISTORY_BITS_RESET = 3'd4;

  localparam logic REG_PC_BITS      = 1'b0;
  localparam logic REG_HISTORY_BITS = 1'b1;

  localparam logic [1:0] CNT_STRONG_NT = 2'd0;
  localparam logic [1:0] CNT_WEAK_NT   = 2'd1;
  localparam logic [1:0] CNT_WEAK_T    = 2'd2;
  localparam logic [1:0] CNT_STRONG_T  = 2'd3;

  function automatic logic [1:0] next_counter(input logic [1:0] c, input logic t);
    logic [1:0] n;
    case (c)
      CNT_STRONG_T:  n = t ? CNT_STRONG_T : CNT_WEAK_T;
      CNT_WEAK_T:    n = t ? CNT_STRONG_T : CNT_STRONG_NT;
      CNT_WEAK_NT:   n = t ? CNT_STRONG_T : CNT_STRONG_NT;
      CNT_STRONG_NT: n = t ? CNT_WEAK_NT : CNT_STRONG_NT;
      default:       n = CNT_STRONG_T;
    endcase
    return n;
  endfunction

endpackage

@@ src/correlating_branch_predictor_core.sv @@
// Correlating branch predictor: 2-bit counter table indexed by address and global history.
// Depends on cbp_pkg and correlating_branch_predictor_core_defines.svh.
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata: branch_address, taken
//  m_axis    out  tvalid/tready        tdata: predicted_taken, mispredicted
//  apb       in   psel/penable/pready  pwdata/prdata: pc_bits, history_bits
//
// One item per cycle while the output is not stalled; a result passes the table read register,
// then the counter update and result register.
// After reset a clearing pass writes strong taken to all 2^(MAX_PC_BITS+MAX_HISTORY_BITS)
// entries (16384 by default), one per cycle; no item is taken meanwhile.
// A stalled output holds one result and one item in the read stage before input stalls.
`include "correlating_branch_predictor_core_defines.svh"

module correlating_branch_predictor_core #(
  parameter int MAX_PC_BITS      = cbp_pkg::MAX_PC_BITS_DEF,
  parameter int MAX_HISTORY_BITS = cbp_pkg::MAX_HISTORY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] branch_address, [32] taken, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] predicted_taken, [1] mispredicted, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbp_pkg::*;

  localparam int IDX_W = MAX_PC_BITS + MAX_HISTORY_BITS;
  localparam int DEPTH = 1 << IDX_W;
  localparam int PCW   = $clog2(MAX_PC_BITS + 1);
  localparam int HKW   = $clog2(MAX_HISTORY_BITS + 1);

  logic [3:0]                  pc_bits;
  logic [2:0]                  history_bits;
  logic [MAX_HISTORY_BITS-1:0] history;
  logic [MAX_HISTORY_BITS-1:0] history_next;

  logic             clr_active;
  logic [IDX_W-1:0] clr_addr;

  logic [1:0]       mem [DEPTH];
  logic [1:0]       rdata;

  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_taken;
  logic             s1_fwd_hit;
  logic [1:0]       s1_fwd_val;

  logic             out_valid;
  logic [7:0]       out_data;

  logic [PCW-1:0]              m_eff;
  logic [HKW-1:0]              k_eff;
  logic [MAX_PC_BITS-1:0]      pc_mask;
  logic [MAX_HISTORY_BITS-1:0] h_mask;
  logic [MAX_HISTORY_BITS-1:0] hist_m;
  logic [MAX_HISTORY_BITS-1:0] hist_sh;
  logic [IDX_W-1:0]            idx_in;
  logic [31:0]                 in_addr;
  logic                        in_taken;
  logic                        accept;
  logic                        s1_adv;
  logic [1:0]                  s1_cnt;
  logic [1:0]                  s1_cnt_next;
  logic                        s1_pred;
  logic                        cfg_wr;

  assign in_addr  = s_axis_tdata[31:0];
  assign in_taken = s_axis_tdata[32];

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_bits      <= PC_BITS_RESET;
      history_bits <= HISTORY_BITS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PC_BITS:      pc_bits      <= pwdata[3:0];
        REG_HISTORY_BITS: history_bits <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PC_BITS:      prdata = {28'd0, pc_bits};
      REG_HISTORY_BITS: prdata = {29'd0, history_bits};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (pc_bits == 4'd0)                 m_eff = PCW'(1);
    else if (32'(pc_bits) > MAX_PC_BITS) m_eff = PCW'(MAX_PC_BITS);
    else                                 m_eff = PCW'(pc_bits);
    if (history_bits == 3'd0)                      k_eff = HKW'(1);
    else if (32'(history_bits) > MAX_HISTORY_BITS) k_eff = HKW'(MAX_HISTORY_BITS);
    else                                           k_eff = HKW'(history_bits);
    for (int i = 0; i < MAX_PC_BITS; i++) pc_mask[i] = (i < int'(m_eff));
    for (int i = 0; i < MAX_HISTORY_BITS; i++) h_mask[i] = (i < int'(k_eff));
    hist_m  = history & h_mask;
    hist_sh = hist_m >> 1;
    for (int i = 0; i < MAX_HISTORY_BITS; i++) begin
      history_next[i] = h_mask[i] & ((i == int'(k_eff) - 1) ? in_taken : hist_sh[i]);
    end
    idx_in = ({in_addr[MAX_PC_BITS-1:0] & pc_mask, {MAX_HISTORY_BITS{1'b0}}}
              >> (HKW'(MAX_HISTORY_BITS) - k_eff)) | IDX_W'(hist_m);
  end

  assign s1_adv        = s1_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~clr_active & (~s1_valid | s1_adv);
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign s1_cnt      = s1_fwd_hit ? s1_fwd_val : rdata;
  assign s1_pred     = s1_cnt[1];
  assign s1_cnt_next = next_counter(s1_cnt, s1_taken);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {IDX_W{1'b1}}) clr_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= CNT_STRONG_T;
    end else if (s1_adv) begin
      mem[s1_idx] <= s1_cnt_next;
    end
    if (accept) rdata <= mem[idx_in];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '1;
      s1_valid <= 1'b0;
    end else begin
      if (accept) history <= history_next;
      if (accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx     <= idx_in;
      s1_taken   <= in_taken;
      s1_fwd_hit <= s1_adv && (s1_idx == idx_in);
      s1_fwd_val <= s1_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_data <= {6'd0, s1_pred ^ s1_taken, s1_pred};
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `CBP_ASSERT_NEXT(a_clear_ends, clk, rst, clr_active && clr_addr == {IDX_W{1'b1}}, !clr_active, "clearing pass did not end")
  `CBP_ASSERT_NOW(a_idle_in_clear, clk, rst, clr_active, !s1_valid && !out_valid && !accept, "item in flight during clearing pass")
  `CBP_ASSERT_NEXT(a_adv_gives_out, clk, rst, s1_adv, out_valid, "advanced item produced no result")
  `CBP_ASSERT_NEXT(a_fwd_same_idx, clk, rst, accept && s1_adv && s1_idx == idx_in, s1_fwd_hit, "missed forward of same-cycle counter write")
  `CBP_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_idx), "stalled read stage lost its item")

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for correlating_branch_predictor_core.
// Streams resolved branches with random gaps and stalls, and checks each prediction against
// a local table/history predictor. Depends on cbp_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbp_pkg::*;

  localparam int TBL_DEPTH = 1 << (MAX_PC_BITS_DEF + MAX_HISTORY_BITS_DEF);
  localparam int LIMIT     = 250000;
  localparam logic [2:0] ADDR_PC_BITS   = {REG_PC_BITS, 2'b00};
  localparam logic [2:0] ADDR_HIST_BITS = {REG_HISTORY_BITS, 2'b00};

  typedef struct packed {
    logic [31:0] addr;
    logic        taken;
  } branch_t;

  typedef struct packed {
    logic pred;
    logic misp;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [31:0] branch_address, [32] taken, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] predicted_taken, [1] mispredicted, rest zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  correlating_branch_predictor_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [1:0] counters [TBL_DEPTH];
  logic [3:0] ghist = 4'hF;
  logic [3:0] pc_bits_q = PC_BITS_RESET;
  logic [2:0] hist_bits_q = HISTORY_BITS_RESET;

  branch_t  branch_q [$];
  outcome_t outcome_q [$];
  logic     steady = 1'b0;
  int       errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_misp = 0;
  int       n_settings = 1;
  int       cycles = 0;

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) counters[i] = CNT_STRONG_T;
  end

  function automatic outcome_t resolve_branch(branch_t b);
    int unsigned m, k, idx, hmask;
    logic [1:0]  c;
    outcome_t    o;
    m = (pc_bits_q == 0) ? 1 : (pc_bits_q > MAX_PC_BITS_DEF) ? MAX_PC_BITS_DEF : pc_bits_q;
    k = (hist_bits_q == 0) ? 1 :
        (hist_bits_q > MAX_HISTORY_BITS_DEF) ? MAX_HISTORY_BITS_DEF : hist_bits_q;
    hmask = (1 << k) - 1;
    idx = ((b.addr & ((32'd1 << m) - 1)) << k) | (ghist & hmask);
    c = counters[idx];
    o.pred = c[1];
    o.misp = c[1] ^ b.taken;
    case (c)
      CNT_STRONG_T: counters[idx] = b.taken ? CNT_STRONG_T : CNT_WEAK_T;
      CNT_WEAK_T:   counters[idx] = b.taken ? CNT_STRONG_T : CNT_STRONG_NT;
      CNT_WEAK_NT:  counters[idx] = b.taken ? CNT_STRONG_T : CNT_STRONG_NT;
      default:      counters[idx] = b.taken ? CNT_WEAK_NT : CNT_STRONG_NT;
    endcase
    ghist = 4'(((ghist & hmask) >> 1) | (int'(b.taken) << (k - 1))) & 4'(hmask);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s at result %0d: got %0d, expected %0d", what, n_checked, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    branch_t nxt;
    logic    fire;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        outcome_q = {outcome_q,
                     resolve_branch(branch_t'{s_axis_tdata[31:0], s_axis_tdata[32]})};
        n_sent++;
      end
      if (fire || !s_axis_tvalid) begin
        if (branch_q.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
          nxt = branch_q.pop_front();
          s_axis_tdata  <= {7'b0, nxt.taken, nxt.addr};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result, tdata", m_axis_tdata, -1);
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tdata[0] !== want.pred)
            report_mismatch("predicted_taken", m_axis_tdata[0], want.pred);
          if (m_axis_tdata[1] !== want.misp)
            report_mismatch("mispredicted", m_axis_tdata[1], want.misp);
          if (m_axis_tdata[7:2] !== 6'b0)
            report_mismatch("tdata fill bits", m_axis_tdata[7:2], 0);
          if (m_axis_tdata[1] === 1'b1) n_misp++;
          n_checked++;
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outcome_q.size());
      $display("FAIL correlating_branch_predictor_core");
      $finish;
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    while (branch_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_PC_BITS) pc_bits_q = data[3:0];
    else if (addr == ADDR_HIST_BITS) hist_bits_q = data[2:0];
  endtask

  task automatic set_widths(int unsigned pcb, int unsigned hb);
    apb_write(ADDR_PC_BITS, pcb);
    apb_write(ADDR_HIST_BITS, hb);
    @(posedge clk);
    n_settings++;
  endtask

  task automatic push_branch(logic [31:0] addr, logic taken);
    branch_q = {branch_q, branch_t'{addr, taken}};
  endtask

  // mostly a few hot branches with biased outcomes, the rest random
  task automatic random_phase(int n);
    logic [31:0] hot [8];
    int          bias [8];
    int          j;
    for (int i = 0; i < 8; i++) begin
      hot[i]  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(63);
      bias[i] = (i < 3) ? 92 : (i < 6) ? 8 : $urandom_range(99);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        j = $urandom_range(7);
        push_branch(hot[j], $urandom_range(99) < bias[j]);
      end else begin
        push_branch($urandom, $urandom_range(1));
      end
    end
    wait_drained();
  endtask

  initial begin
    int unsigned pcs [8];
    int unsigned hbs [8];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);

    // reset widths: extremes of the address and both outcomes
    push_branch(32'h0000_0000, 1'b1);
    push_branch(32'h0000_0000, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'hFFFF_FFFF, 1'b1);
    push_branch(32'hAAAA_AAAA, 1'b1);
    push_branch(32'h5555_5555, 1'b0);
    push_branch(32'h0000_03FF, 1'b0);
    wait_drained();

    // zero widths act as one; walk one counter through every state
    set_widths(0, 0);
    push_branch(32'h0, 1'b1);
    push_branch(32'h0, 1'b0);
    push_branch(32'h0, 1'b0);
    push_branch(32'h0, 1'b0);
    push_branch(32'h0, 1'b1);
    push_branch(32'h0, 1'b1);
    push_branch(32'h0, 1'b0);
    push_branch(32'h0, 1'b1);
    push_branch(32'h1, 1'b1);
    wait_drained();

    // oversized widths act as the maximum
    set_widths(15, 7);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'hFFFF_FC00, 1'b0);
    push_branch(32'h0000_0400, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    pcs = '{1, 10, 15, 0, 0, 0, 0, 0};
    hbs = '{1, 4, 7, 5, 0, 0, 0, 0};
    for (int p = 3; p < 8; p++) begin
      pcs[p] = $urandom_range(15);
      hbs[p] = $urandom_range(7);
    end
    pcs[3] = 0;
    for (int p = 0; p < 8; p++) begin
      set_widths(pcs[p], hbs[p]);
      steady = (p == 4);
      random_phase(228);
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch("results never arrived, count", 0, outcome_q.size());
    $display("Ran %0d branches over %0d width settings; %0d results checked, %0d mispredicted.",
             n_sent, n_settings, n_checked, n_misp);
    if (errors == 0) begin
      $display("PASS correlating_branch_predictor_core");
    end else begin
      $display("FAIL correlating_branch_predictor_core");
    end
    $finish;
  end

endmodule
